// ===== rtl/core/dllm_pkg.sv =====
// dllm_pkg: shared types and constants for the doubly linked list manager
// no dependencies; used by doubly_linked_list_manager and its testbench
package dllm_pkg;

  localparam int LINK_W = 7;
  localparam int DATA_W = 32;
  localparam logic [LINK_W-1:0] NULL_LINK = 7'd127;

  typedef enum logic [2:0] {
    ACT_APPEND     = 3'd0,
    ACT_REMOVE     = 3'd1,
    ACT_INS_POS    = 3'd2,
    ACT_DEL_POS    = 3'd3,
    ACT_INS_AFTER  = 3'd4,
    ACT_INS_BEFORE = 3'd5,
    ACT_READ       = 3'd6,
    ACT_REVERSE    = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_BAD_POS   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    LM_END    = 2'd0,
    LM_AFTER  = 2'd1,
    LM_BEFORE = 2'd2
  } link_mode_t;

endpackage

// ===== rtl/core/dllm_ram.sv =====
// dllm_ram: single write port, single read port memory with registered read
// no dependencies; one instance per slot store of the list manager
module dllm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

endmodule

// ===== rtl/core/doubly_linked_list_manager.sv =====
// doubly_linked_list_manager: list of signed values in slot memories, one command at a time
// depends on dllm_pkg and dllm_ram
//
//  channel  | signals                            | direction
//  request  | req_valid req_stall action value   | in (req_stall out)
//           | position key                       |
//  result   | res_valid res_stall status         | out (res_stall in)
//           | has_item item last                 |
//
// a command may walk the nodes for a position, key or reverse walk, or emit
// them for a read out; every node step is one read of the link memories
// reset empties the list at once; the free slot stack uses per-entry valid bits
// req_stall is high whenever a command is in progress
// a stalled result holds the sequencer before it loads the next result
module doubly_linked_list_manager
  import dllm_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [2:0]         action,
  input  logic signed [31:0] value,
  input  logic [6:0]         position,
  input  logic signed [31:0] key,
  output logic               res_valid,
  input  logic               res_stall,
  output logic [2:0]         status,
  output logic               has_item,
  output logic signed [31:0] item,
  output logic               last
);

  localparam int SW = $clog2(CAPACITY);
  localparam logic [7:0] CAP8 = 8'(CAPACITY);

  typedef enum logic [22:0] {
    S_IDLE   = 23'h000001,
    S_DISP   = 23'h000002,
    S_TAKE_R = 23'h000004,
    S_TAKE_D = 23'h000008,
    S_LINK   = 23'h000010,
    S_LA_R   = 23'h000020,
    S_LA_D   = 23'h000040,
    S_LA_W   = 23'h000080,
    S_LB_R   = 23'h000100,
    S_LB_D   = 23'h000200,
    S_LB_W   = 23'h000400,
    S_U_R    = 23'h000800,
    S_U_D    = 23'h001000,
    S_W_CHK  = 23'h002000,
    S_W_D    = 23'h004000,
    S_S_CHK  = 23'h008000,
    S_S_D    = 23'h010000,
    S_R_CHK  = 23'h020000,
    S_R_D    = 23'h040000,
    S_R_EMIT = 23'h080000,
    S_V_CHK  = 23'h100000,
    S_V_D    = 23'h200000,
    S_DONE   = 23'h400000
  } state_t;

  state_t state;
  action_t act;
  link_mode_t mode;
  status_t st;
  logic [DATA_W-1:0] value_r, key_r, item_r;
  logic [6:0] position_r;
  logic [LINK_W-1:0] first, tail, cur, ns, lnk;
  logic [6:0] count, idx;
  logic fin;
  logic [CAPACITY-1:0] free_vld;
  logic fvld_q;
  logic [SW-1:0] free_ra_q;

  logic [SW-1:0] ra;
  logic [DATA_W-1:0] val_q;
  logic [LINK_W-1:0] fwd_q, bwd_q;
  logic [SW-1:0] free_q, free_slot;
  logic val_we, fwd_we, bwd_we, free_we;
  logic [SW-1:0] val_wa, fwd_wa, bwd_wa, free_wa;
  logic [LINK_W-1:0] fwd_wd, bwd_wd;
  logic out_free;
  logic res_load;
  logic [7:0] count8, idx8;
  logic [6:0] count_dec;

  assign ra = cur[SW-1:0];
  assign free_slot = fvld_q ? free_q : free_ra_q;
  assign out_free = !res_valid || !res_stall;
  assign res_load = (state == S_R_EMIT || state == S_DONE) && out_free;
  assign req_stall = (state != S_IDLE);
  assign count8 = {1'b0, count};
  assign idx8 = {1'b0, idx};
  assign count_dec = count - 7'd1;

  dllm_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_val (
    .clk(clk), .we(val_we), .wa(val_wa), .wd(value_r), .ra(ra), .rd(val_q)
  );
  dllm_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_fwd (
    .clk(clk), .we(fwd_we), .wa(fwd_wa), .wd(fwd_wd), .ra(ra), .rd(fwd_q)
  );
  dllm_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_bwd (
    .clk(clk), .we(bwd_we), .wa(bwd_wa), .wd(bwd_wd), .ra(ra), .rd(bwd_q)
  );
  dllm_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_free (
    .clk(clk), .we(free_we), .wa(free_wa), .wd(cur[SW-1:0]),
    .ra(count[SW-1:0]), .rd(free_q)
  );

  // memory write controls
  always_comb begin
    val_we  = 1'b0;
    val_wa  = free_slot;
    fwd_we  = 1'b0;
    fwd_wa  = ns[SW-1:0];
    fwd_wd  = NULL_LINK;
    bwd_we  = 1'b0;
    bwd_wa  = ns[SW-1:0];
    bwd_wd  = NULL_LINK;
    free_we = 1'b0;
    free_wa = count_dec[SW-1:0];
    unique case (state)
      S_TAKE_D: begin
        val_we = 1'b1;
      end
      S_LINK: begin
        if (mode == LM_END && tail == NULL_LINK) begin
          fwd_we = 1'b1;
          bwd_we = 1'b1;
        end
      end
      S_LA_D: begin
        fwd_we = 1'b1;
        fwd_wd = fwd_q;
        bwd_we = 1'b1;
        bwd_wd = cur;
      end
      S_LA_W: begin
        fwd_we = 1'b1;
        fwd_wa = cur[SW-1:0];
        fwd_wd = ns;
        bwd_we = (lnk != NULL_LINK);
        bwd_wa = lnk[SW-1:0];
        bwd_wd = ns;
      end
      S_LB_D: begin
        fwd_we = 1'b1;
        fwd_wd = cur;
        bwd_we = 1'b1;
        bwd_wd = bwd_q;
      end
      S_LB_W: begin
        fwd_we = (lnk != NULL_LINK);
        fwd_wa = lnk[SW-1:0];
        fwd_wd = ns;
        bwd_we = 1'b1;
        bwd_wa = cur[SW-1:0];
        bwd_wd = ns;
      end
      S_U_D: begin
        fwd_we  = (bwd_q != NULL_LINK);
        fwd_wa  = bwd_q[SW-1:0];
        fwd_wd  = fwd_q;
        bwd_we  = (fwd_q != NULL_LINK);
        bwd_wa  = fwd_q[SW-1:0];
        bwd_wd  = bwd_q;
        free_we = 1'b1;
      end
      S_V_D: begin
        fwd_we = 1'b1;
        fwd_wa = cur[SW-1:0];
        fwd_wd = bwd_q;
        bwd_we = 1'b1;
        bwd_wa = cur[SW-1:0];
        bwd_wd = fwd_q;
      end
      default: begin
      end
    endcase
  end

  // free stack valid bits and registered read index
  always_ff @(posedge clk) begin
    free_ra_q <= count[SW-1:0];
    fvld_q    <= free_vld[count[SW-1:0]];
    if (rst) begin
      free_vld <= '0;
    end else if (free_we) begin
      free_vld[free_wa] <= 1'b1;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      first     <= NULL_LINK;
      tail      <= NULL_LINK;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && !res_stall && !res_load) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            act        <= action_t'(action);
            value_r    <= value;
            key_r      <= key;
            position_r <= position;
            st         <= ST_OK;
            state      <= S_DISP;
          end
        end
        S_DISP: begin
          case (act) inside
            ACT_APPEND: begin
              if (count8 >= CAP8) begin
                st    <= ST_FULL;
                state <= S_DONE;
              end else begin
                mode  <= LM_END;
                state <= S_TAKE_R;
              end
            end
            ACT_REMOVE: begin
              if (tail == NULL_LINK || count == 7'd0) begin
                st    <= ST_EMPTY;
                state <= S_DONE;
              end else begin
                cur   <= tail;
                state <= S_U_R;
              end
            end
            ACT_INS_POS: begin
              if (count8 >= CAP8) begin
                st    <= ST_FULL;
                state <= S_DONE;
              end else if (position_r == 7'd0 || {1'b0, position_r} > count8 + 8'd1) begin
                st    <= ST_BAD_POS;
                state <= S_DONE;
              end else if ({1'b0, position_r} == count8 + 8'd1) begin
                mode  <= LM_END;
                state <= S_TAKE_R;
              end else begin
                mode  <= LM_BEFORE;
                cur   <= first;
                idx   <= 7'd1;
                state <= S_W_CHK;
              end
            end
            ACT_DEL_POS: begin
              if (position_r == 7'd0 || position_r > count) begin
                st    <= ST_BAD_POS;
                state <= S_DONE;
              end else begin
                cur   <= first;
                idx   <= 7'd1;
                state <= S_W_CHK;
              end
            end
            ACT_INS_AFTER, ACT_INS_BEFORE: begin
              if (count8 >= CAP8) begin
                st    <= ST_FULL;
                state <= S_DONE;
              end else begin
                mode  <= (act == ACT_INS_AFTER) ? LM_AFTER : LM_BEFORE;
                cur   <= first;
                idx   <= 7'd0;
                state <= S_S_CHK;
              end
            end
            ACT_READ: begin
              if (count == 7'd0 || first == NULL_LINK) begin
                st    <= ST_OK;
                state <= S_DONE;
              end else begin
                cur   <= first;
                idx   <= 7'd0;
                state <= S_R_CHK;
              end
            end
            default: begin
              cur   <= first;
              idx   <= 7'd0;
              state <= S_V_CHK;
            end
          endcase
        end
        S_TAKE_R: state <= S_TAKE_D;
        S_TAKE_D: begin
          ns    <= {{(LINK_W-SW){1'b0}}, free_slot};
          count <= count + 7'd1;
          state <= S_LINK;
        end
        S_LINK: begin
          case (mode)
            LM_END: begin
              if (tail == NULL_LINK) begin
                first <= ns;
                tail  <= ns;
                state <= S_DONE;
              end else begin
                cur   <= tail;
                state <= S_LA_R;
              end
            end
            LM_AFTER: state <= S_LA_R;
            default:  state <= S_LB_R;
          endcase
        end
        S_LA_R: state <= S_LA_D;
        S_LA_D: begin
          lnk   <= fwd_q;
          state <= S_LA_W;
        end
        S_LA_W: begin
          if (lnk == NULL_LINK) begin
            tail <= ns;
          end
          state <= S_DONE;
        end
        S_LB_R: state <= S_LB_D;
        S_LB_D: begin
          lnk   <= bwd_q;
          state <= S_LB_W;
        end
        S_LB_W: begin
          if (lnk == NULL_LINK) begin
            first <= ns;
          end
          state <= S_DONE;
        end
        S_U_R: state <= S_U_D;
        S_U_D: begin
          if (bwd_q == NULL_LINK) begin
            first <= fwd_q;
          end
          if (fwd_q == NULL_LINK) begin
            tail <= bwd_q;
          end
          count <= count_dec;
          state <= S_DONE;
        end
        S_W_CHK: begin
          if (idx < position_r) begin
            state <= S_W_D;
          end else if (act == ACT_DEL_POS) begin
            state <= S_U_R;
          end else begin
            state <= S_TAKE_R;
          end
        end
        S_W_D: begin
          cur   <= fwd_q;
          idx   <= idx + 7'd1;
          state <= S_W_CHK;
        end
        S_S_CHK: begin
          if (idx < count && cur != NULL_LINK) begin
            state <= S_S_D;
          end else begin
            st    <= ST_NOT_FOUND;
            state <= S_DONE;
          end
        end
        S_S_D: begin
          if (val_q == key_r) begin
            state <= S_TAKE_R;
          end else begin
            cur   <= fwd_q;
            idx   <= idx + 7'd1;
            state <= S_S_CHK;
          end
        end
        S_R_CHK: state <= S_R_D;
        S_R_D: begin
          item_r <= val_q;
          lnk    <= fwd_q;
          fin    <= (idx8 + 8'd1 >= count8) || (fwd_q == NULL_LINK);
          state  <= S_R_EMIT;
        end
        S_R_EMIT: begin
          if (out_free) begin
            res_valid <= 1'b1;
            status    <= ST_OK;
            has_item  <= 1'b1;
            item      <= item_r;
            last      <= fin;
            if (fin) begin
              state <= S_IDLE;
            end else begin
              cur   <= lnk;
              idx   <= idx + 7'd1;
              state <= S_R_CHK;
            end
          end
        end
        S_V_CHK: begin
          if (idx < count && cur != NULL_LINK) begin
            state <= S_V_D;
          end else begin
            first <= tail;
            tail  <= first;
            state <= S_DONE;
          end
        end
        S_V_D: begin
          cur   <= fwd_q;
          idx   <= idx + 7'd1;
          state <= S_V_CHK;
        end
        S_DONE: begin
          if (out_free) begin
            res_valid <= 1'b1;
            status    <= st;
            has_item  <= 1'b0;
            item      <= '0;
            last      <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count8 <= CAP8) else $error("node count above capacity");

  a_empty_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && count == 7'd0) |-> (first == NULL_LINK && tail == NULL_LINK))
    else $error("empty list with live end pointer");

  a_live_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && count != 7'd0) |-> (first != NULL_LINK && tail != NULL_LINK))
    else $error("non-empty list with null end pointer");

  a_read_item: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !has_item) |-> last)
    else $error("non read-out result without last");

endmodule

// ===== sim/doubly_linked_list_manager_tb.sv =====
// doubly_linked_list_manager_tb: random and directed test of the linked list manager
// holds its own list predictor inside a scoreboard class; depends on dllm_pkg and the rtl
`timescale 1ns / 1ps

module doubly_linked_list_manager_tb;
  import dllm_pkg::*;

  localparam int CAP = 64;

  typedef struct packed {
    status_t            status;
    logic               has_item;
    logic signed [31:0] item;
    logic               last;
  } list_result_t;

  class list_scoreboard;
    logic signed [31:0] vals [$];
    list_result_t pending [$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function void push_status(status_t st);
      list_result_t r;
      r.status = st;
      r.has_item = 1'b0;
      r.item = '0;
      r.last = 1'b1;
      pending.push_back(r);
    endfunction

    function void note_request(action_t act, logic signed [31:0] v, logic [6:0] pos,
                               logic signed [31:0] k);
      int idx;
      bit full;
      list_result_t r;
      full = vals.size() >= CAP;
      idx = -1;
      if (act == ACT_INS_AFTER || act == ACT_INS_BEFORE) begin
        for (int i = 0; i < vals.size(); i++) begin
          if (vals[i] == k) begin
            idx = i;
            break;
          end
        end
      end
      case (act) inside
        ACT_APPEND: begin
          if (full) push_status(ST_FULL);
          else begin
            vals.push_back(v);
            push_status(ST_OK);
          end
        end
        ACT_REMOVE: begin
          if (vals.size() == 0) push_status(ST_EMPTY);
          else begin
            void'(vals.pop_back());
            push_status(ST_OK);
          end
        end
        ACT_INS_POS: begin
          if (full) push_status(ST_FULL);
          else if (pos < 1 || pos > vals.size() + 1) push_status(ST_BAD_POS);
          else begin
            vals.insert(pos - 1, v);
            push_status(ST_OK);
          end
        end
        ACT_DEL_POS: begin
          if (pos < 1 || pos > vals.size()) push_status(ST_BAD_POS);
          else begin
            vals.delete(pos - 1);
            push_status(ST_OK);
          end
        end
        ACT_INS_AFTER, ACT_INS_BEFORE: begin
          if (full) push_status(ST_FULL);
          else if (idx < 0) push_status(ST_NOT_FOUND);
          else begin
            vals.insert(act == ACT_INS_AFTER ? idx + 1 : idx, v);
            push_status(ST_OK);
          end
        end
        ACT_READ: begin
          if (vals.size() == 0) push_status(ST_OK);
          else begin
            for (int i = 0; i < vals.size(); i++) begin
              r.status = ST_OK;
              r.has_item = 1'b1;
              r.item = vals[i];
              r.last = (i == vals.size() - 1);
              pending.push_back(r);
            end
          end
        end
        default: begin
          for (int i = 0; i < vals.size() / 2; i++) begin
            logic signed [31:0] t;
            t = vals[i];
            vals[i] = vals[vals.size() - 1 - i];
            vals[vals.size() - 1 - i] = t;
          end
          push_status(ST_OK);
        end
      endcase
    endfunction

    task report(string field, longint got, longint want);
      $display("error: %s got %0d want %0d", field, got, want);
      errors++;
    endtask

    task check_result(list_result_t got);
      list_result_t want;
      if (pending.size() == 0) begin
        report("unexpected result status", got.status, -1);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) report("status", got.status, want.status);
      if (got.has_item !== want.has_item) report("has_item", got.has_item, want.has_item);
      if (got.item !== want.item) report("item", got.item, want.item);
      if (got.last !== want.last) report("last", got.last, want.last);
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic req_valid = 0;
  logic req_stall;
  logic [2:0] action = '0;
  logic signed [31:0] value = '0;
  logic [6:0] position = '0;
  logic signed [31:0] key = '0;
  logic res_valid;
  logic res_stall = 1;
  logic [2:0] status;
  logic has_item;
  logic signed [31:0] item;
  logic last;

  list_scoreboard sb = new();
  bit hold_long = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  doubly_linked_list_manager u_top (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall),
    .action(action), .value(value), .position(position), .key(key),
    .res_valid(res_valid), .res_stall(res_stall), .status(status),
    .has_item(has_item), .item(item), .last(last)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_request(action_t act, logic signed [31:0] v, logic [6:0] pos,
                              logic signed [31:0] k);
    int gap;
    action <= act;
    value <= v;
    position <= pos;
    key <= k;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    sb.note_request(act, v, pos, k);
    gap = gap_len();
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 15);
    if (r == 6) return 32'sh7fffffff;
    if (r == 7) return 32'sh80000000;
    return $urandom;
  endfunction

  function automatic logic signed [31:0] pick_key();
    if (sb.vals.size() != 0 && $urandom_range(0, 3) != 0)
      return sb.vals[$urandom_range(0, sb.vals.size() - 1)];
    return pick_value();
  endfunction

  task automatic random_request();
    action_t act;
    int n;
    logic [6:0] pos;
    n = sb.vals.size();
    act = action_t'($urandom_range(0, 7));
    if (act == ACT_READ && $urandom_range(0, 2) != 0) act = ACT_APPEND;
    if ($urandom_range(0, 9) == 0) pos = 7'($urandom);
    else pos = 7'($urandom_range(0, n + 2));
    send_request(act, pick_value(), pos, pick_key());
  endtask

  // result side: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst) res_stall <= 1'b1;
    else if (hold_long) res_stall <= 1'b1;
    else res_stall <= ($urandom_range(0, 99) < 30);
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall)
      sb.check_result('{status_t'(status), has_item, item, last});
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed corners
    send_request(ACT_REMOVE, 0, 0, 0);
    send_request(ACT_DEL_POS, 0, 1, 0);
    send_request(ACT_READ, 0, 0, 0);
    send_request(ACT_INS_AFTER, 1, 0, 5);
    send_request(ACT_REVERSE, 0, 0, 0);
    send_request(ACT_INS_POS, 32'sh7fffffff, 0, 0);
    send_request(ACT_INS_POS, 32'sh7fffffff, 1, 0);
    send_request(ACT_REVERSE, 0, 0, 0);
    send_request(ACT_APPEND, 32'sh80000000, 7'h7f, 32'sh7fffffff);
    send_request(ACT_INS_BEFORE, -1, 0, 32'sh80000000);
    send_request(ACT_INS_AFTER, 32'sh55555555, 0, 32'sh7fffffff);
    send_request(ACT_INS_POS, 32'shaaaaaaaa, 3, -1);
    send_request(ACT_INS_BEFORE, 9, 0, 12345);
    send_request(ACT_READ, 0, 0, 0);
    send_request(ACT_REVERSE, 0, 0, 0);
    send_request(ACT_READ, 0, 0, 0);
    send_request(ACT_DEL_POS, 0, 6, 0);
    send_request(ACT_DEL_POS, 0, 2, 0);
    send_request(ACT_REMOVE, 0, 0, 0);
    // fill to capacity while the result side holds off
    fork
      begin
        hold_long = 1;
        repeat (300) @(posedge clk);
        hold_long = 0;
      end
      while (sb.vals.size() < CAP) send_request(ACT_APPEND, pick_value(), 0, 0);
    join
    send_request(ACT_APPEND, 1, 0, 0);
    send_request(ACT_INS_POS, 1, 1, 0);
    send_request(ACT_INS_AFTER, 1, 0, sb.vals[0]);
    send_request(ACT_INS_BEFORE, 1, 0, 32'sh12344321);
    send_request(ACT_DEL_POS, 0, 64, 0);
    send_request(ACT_READ, 0, 0, 0);
    while (sb.vals.size() > 40)
      send_request(ACT_DEL_POS, 0, 7'($urandom_range(1, sb.vals.size())), 0);
    for (int i = 0; i < 40; i++) begin
      random_request();
      if (i % 20 == 19) send_request(ACT_READ, 0, 0, 0);
    end
    send_request(ACT_READ, 0, 0, 0);
    req_valid <= 1'b0;
    wait_drained();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
